// ===== hdl/vwma_pkg.sv =====
// Shared constants and types for the variable window moving average.
// No dependencies; imported by vwma_div and variable_window_moving_average_top.
package vwma_pkg;

  localparam int MaxSamples = 64;                       // ring depth
  localparam int SampleW    = 25;                       // sample / average width
  localparam int WinW       = 7;                        // window register width
  localparam int PtrW       = $clog2(MaxSamples);       // ring index width
  localparam int CntW       = $clog2(MaxSamples + 1);   // fill count / window width
  localparam int SumW       = SampleW + $clog2(MaxSamples);
  localparam int DivCntW    = $clog2(SumW + 1);

  localparam logic [WinW-1:0] WinReset = WinW'(8);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_START,
    ST_DIV,
    ST_DONE
  } vwma_state_e;

endpackage

// ===== hdl/variable_window_moving_average_top.sv =====
// Moving average over the last window_length samples (1..MaxSamples; zero acts as 1,
// larger values as MaxSamples). Once a sample is accepted, its average is built in
// steps: the sum update in ST_READ (the ring read rides on the accepting edge), the
// divider load in ST_START, SumW (31) steps of the bit-serial divider, which sets the
// rate, and a register stage for the average. The next sample is taken only once the
// block is back in ST_IDLE, after the average is loaded into the output register. One
// sample is in work at a time; a finished average waits in the output register while
// the next sample is taken. Writing window_length clears the window, count and sum.
// Depends on vwma_pkg and vwma_div.
module variable_window_moving_average_top import vwma_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic signed [SampleW-1:0] sample_i,
  input  logic                      sample_valid_i,
  output logic                      sample_stall_o,
  output logic signed [SampleW-1:0] average_o,
  output logic                      average_valid_o,
  input  logic                      average_stall_i,
  input  logic        [WinW-1:0]    window_length_i,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o
);

  vwma_state_e state_q, state_d;

  logic        [WinW-1:0]    win_q;
  logic        [PtrW-1:0]    old_ptr_q, old_ptr_d;
  logic        [PtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic        [CntW-1:0]    fill_q, fill_d;
  logic signed [SumW-1:0]    sum_q, sum_d;
  logic signed [SampleW-1:0] sample_q;
  logic signed [SampleW-1:0] rd_data_q;
  logic signed [SampleW-1:0] avg_q;
  logic                      out_valid_q;

  logic signed [SampleW-1:0] ring_mem [MaxSamples];

  logic [CntW-1:0] win_eff;
  logic [PtrW-1:0] old_eff, wr_eff;
  logic [CntW-1:0] fill_eff;
  logic            full;
  logic            cfg_wr, in_req, out_take, out_free;
  logic            div_start, div_done, load_out;
  logic signed [SumW-1:0] div_quot;

  // effective window and guarded state
  always_comb begin
    if (win_q == '0) begin
      win_eff = CntW'(1);
    end else if (int'(win_q) > MaxSamples) begin
      win_eff = CntW'(MaxSamples);
    end else begin
      win_eff = CntW'(win_q);
    end
  end

  assign old_eff  = (CntW'(old_ptr_q) >= win_eff) ? '0 : old_ptr_q;
  assign wr_eff   = (CntW'(wr_ptr_q) >= win_eff) ? '0 : wr_ptr_q;
  assign fill_eff = (fill_q > win_eff) ? win_eff : fill_q;
  assign full     = fill_eff == win_eff;

  assign cfg_wr   = cfg_valid_i && cfg_ready_o;
  assign in_req   = sample_valid_i && !sample_stall_o;
  assign out_take = out_valid_q && !average_stall_i;
  assign out_free = !out_valid_q || !average_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_req) state_d = ST_READ;
      ST_READ:  state_d = ST_START;
      ST_START: state_d = ST_DIV;
      ST_DIV:   if (div_done) state_d = out_free ? ST_IDLE : ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    sample_stall_o = 1'b1;
    cfg_ready_o    = 1'b0;
    div_start      = 1'b0;
    load_out       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cfg_ready_o    = 1'b1;
        sample_stall_o = cfg_valid_i;
      end
      ST_START: div_start = 1'b1;
      ST_DIV:   load_out  = div_done && out_free;
      ST_DONE:  load_out  = out_free;
      default: ;
    endcase
  end

  // running state update once the oldest sample is back from the ring
  always_comb begin
    old_ptr_d = old_ptr_q;
    wr_ptr_d  = wr_ptr_q;
    fill_d    = fill_q;
    sum_d     = sum_q;
    if (state_q == ST_READ) begin
      if (full) begin
        old_ptr_d = (CntW'(old_eff) + CntW'(1) == win_eff) ? '0 : old_eff + PtrW'(1);
        fill_d    = fill_eff;
        sum_d     = sum_q - SumW'(rd_data_q) + SumW'(sample_q);
      end else begin
        old_ptr_d = old_eff;
        fill_d    = fill_eff + CntW'(1);
        sum_d     = sum_q + SumW'(sample_q);
      end
      wr_ptr_d = (CntW'(wr_eff) + CntW'(1) == win_eff) ? '0 : wr_eff + PtrW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      win_q       <= WinReset;
      old_ptr_q   <= '0;
      wr_ptr_q    <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        win_q     <= window_length_i;
        old_ptr_q <= '0;
        wr_ptr_q  <= '0;
        fill_q    <= '0;
        sum_q     <= '0;
      end else begin
        old_ptr_q <= old_ptr_d;
        wr_ptr_q  <= wr_ptr_d;
        fill_q    <= fill_d;
        sum_q     <= sum_d;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_req) begin
      sample_q <= sample_i;
    end
    if (load_out) begin
      avg_q <= div_quot[SampleW-1:0];
    end
  end

  // sample ring: read oldest on request, write new sample in the following cycle (ST_READ)
  always_ff @(posedge clk_i) begin
    if (in_req) begin
      rd_data_q <= ring_mem[old_eff];
    end
    if (state_q == ST_READ) begin
      ring_mem[wr_eff] <= sample_q;
    end
  end

  vwma_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (fill_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign average_o       = avg_q;
  assign average_valid_o = out_valid_q;

endmodule

// ===== hdl/vwma_div.sv =====
// Bit-serial signed divider: sum / count, truncated toward zero.
// One quotient bit per cycle. Uses vwma_pkg.
module vwma_div import vwma_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [SumW-1:0] dividend_i,
  input  logic        [CntW-1:0] divisor_i,
  output logic                   done_o,
  output logic signed [SumW-1:0] quot_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [SumW-1:0]    dvd_q, dvd_d;
  logic [CntW:0]      rem_q, rem_d;
  logic [CntW-1:0]    dvs_q, dvs_d;
  logic               neg_q, neg_d;

  logic [CntW:0]      rem_sh;
  logic               ge;
  logic [SumW-1:0]    mag;

  assign mag    = dividend_i[SumW-1] ? SumW'(-dividend_i) : SumW'(dividend_i);
  assign rem_sh = {rem_q[CntW-1:0], dvd_q[SumW-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DivCntW'(SumW);
      dvd_d  = mag;
      rem_d  = '0;
      dvs_d  = divisor_i;
      neg_d  = dividend_i[SumW-1];
    end else if (busy_q) begin
      rem_d = ge ? rem_sh - {1'b0, dvs_q} : rem_sh;
      dvd_d = {dvd_q[SumW-2:0], ge};
      cnt_d = cnt_q - DivCntW'(1);
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  // magnitude quotient, sign restored
  assign done_o = done_q;
  assign quot_o = neg_q ? signed'(-dvd_q) : signed'(dvd_q);

endmodule
